@@ hdl/trusted_canonical_kmer_extractor_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the canonical k-mer extractor checker
// ----------------------------------------------------------------------------
`ifndef TRUSTED_CANONICAL_KMER_EXTRACTOR_DEFINES_SVH
`define TRUSTED_CANONICAL_KMER_EXTRACTOR_DEFINES_SVH

// Property that must hold on every clock edge outside reset
`define TCKE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication, same cycle
`define TCKE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication, next cycle
`define TCKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tcke_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcke_pkg
// Shared types, constants and base decoding for the canonical k-mer extractor.
// ----------------------------------------------------------------------------
package tcke_pkg;

    localparam int BUCKET_BITS  = 8;
    localparam int MAX_KMER_LEN = 32;

    localparam int KMER_W   = 64;
    localparam int LANES    = KMER_W / 2;
    localparam int TRUST_W  = 32;
    localparam int KLEN_W   = 6;
    localparam int CHAR_W   = 8;
    localparam int BUCKET_W = 8;

    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(31);
    localparam logic [KLEN_W-1:0] KLEN_MAX   = KLEN_W'(MAX_KMER_LEN);
    localparam logic [KLEN_W-1:0] KLEN_MIN   = KLEN_W'(1);

    localparam logic [KMER_W-1:0] BUCKET_MASK = (KMER_W'(1) << BUCKET_BITS) - KMER_W'(1);

    // Base codes; bit 2 set marks a letter outside ACGT
    localparam logic [2:0] CODE_A   = 3'd0;
    localparam logic [2:0] CODE_C   = 3'd1;
    localparam logic [2:0] CODE_G   = 3'd2;
    localparam logic [2:0] CODE_T   = 3'd3;
    localparam logic [2:0] CODE_BAD = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic              base_error;
        logic              read_start;
    } base_item_t;

    function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [2:0] code;
        case (ch)
            "A", "a": code = CODE_A;
            "C", "c": code = CODE_C;
            "G", "g": code = CODE_G;
            "T", "t": code = CODE_T;
            default:  code = CODE_BAD;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/trusted_canonical_kmer_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trusted_canonical_kmer_extractor
// Canonical 2-bit k-mer extractor with a base trust window.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one read base per item with its error
// flag and read-start mark. Output channel (out_valid/out_ready): exactly one
// result item per input item, in order: kmer_valid, canonical_kmer, bucket.
// cfg_wr_en/cfg_wr_data write the k-mer length; write only while idle.
// An accepted item sits in the input register and moves into the result
// register when the core takes it, which waits while a stalled result is
// held. Throughput is one item per cycle while the receiver takes results;
// the limit is the state update (k-mer shift, 64-bit compare, run counter).
// A stalled receiver holds the result register; the input register still
// takes one more item, after which in_ready drops until the result is taken.
// Reset sets k to 31 and clears the k-mers, run count and trust window.
// ----------------------------------------------------------------------------
module trusted_canonical_kmer_extractor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcke_pkg::CHAR_W-1:0]    base_char,
    input  logic                           base_error,
    input  logic                           read_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           kmer_valid,
    output logic [tcke_pkg::KMER_W-1:0]    canonical_kmer,
    output logic [tcke_pkg::BUCKET_W-1:0]  bucket,
    input  logic                           cfg_wr_en,
    input  logic [tcke_pkg::KLEN_W-1:0]    cfg_wr_data
);
    import tcke_pkg::*;

    logic [KLEN_W-1:0] kmer_len_reg;
    logic [KLEN_W-1:0] kmer_len_next;
    base_item_t        item_in;
    base_item_t        item_held;
    logic              hold_valid;
    logic              take;

    assign kmer_len_next = cfg_wr_en ? cfg_wr_data : kmer_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= KLEN_RESET;
        end
        else
        begin
            kmer_len_reg <= kmer_len_next;
        end
    end

    assign item_in.base_char  = base_char;
    assign item_in.base_error = base_error;
    assign item_in.read_start = read_start;

    tcke_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .take       (take),
        .hold_valid (hold_valid),
        .item_out   (item_held)
    );

    tcke_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .hold_valid     (hold_valid),
        .item           (item_held),
        .kmer_len       (kmer_len_reg),
        .take           (take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kmer_valid     (kmer_valid),
        .canonical_kmer (canonical_kmer),
        .bucket         (bucket)
    );

endmodule

@@ hdl/tcke_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcke_in_stage
// Input register: captures one base item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tcke_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcke_pkg::base_item_t item_in,
    input  logic               take,
    output logic               hold_valid,
    output tcke_pkg::base_item_t item_out
);
    import tcke_pkg::*;

    logic       hold_valid_reg;
    logic       hold_valid_next;
    base_item_t item_reg;
    logic       load;

    // Free slot, or the held item leaves this cycle
    assign in_ready = !hold_valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (load)
        begin
            hold_valid_next = 1'b1;
        end
        else if (take)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign item_out   = item_reg;

endmodule

@@ hdl/tcke_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcke_core
// K-mer state update and result register: shifts the base into the forward
// and reverse-complement k-mers, tracks run length and trust window, and
// registers the canonical k-mer for the output channel.
// ----------------------------------------------------------------------------
module tcke_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 hold_valid,
    input  tcke_pkg::base_item_t                 item,
    input  logic [tcke_pkg::KLEN_W-1:0]          kmer_len,
    output logic                                 take,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 kmer_valid,
    output logic [tcke_pkg::KMER_W-1:0]          canonical_kmer,
    output logic [tcke_pkg::BUCKET_W-1:0]        bucket
);
    import tcke_pkg::*;

    logic [KMER_W-1:0]  fwd_reg, fwd_next;
    logic [KMER_W-1:0]  rev_reg, rev_next;
    logic [KLEN_W-1:0]  run_reg, run_next;
    logic [TRUST_W-1:0] hist_reg, hist_next;

    logic                out_valid_reg, out_valid_next;
    logic                kmer_valid_reg, kmer_valid_next;
    logic [KMER_W-1:0]   canon_reg, canon_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;

    logic [KLEN_W-1:0]  k_eff;
    logic [KLEN_W-1:0]  k_top;
    logic [2:0]         code;
    logic               base_ok;
    logic [KMER_W-1:0]  fwd_cur, rev_cur, rev_shift, rev_ins, fmask, canon;
    logic [KLEN_W-1:0]  run_cur;
    logic [TRUST_W-1:0] hist_cur, tmask;
    logic               trust_ok;
    logic               emit;

    assign take = hold_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        // Out-of-range lengths clamp to 1..MAX_KMER_LEN
        if (kmer_len < KLEN_MIN)
        begin
            k_eff = KLEN_MIN;
        end
        else if (kmer_len > KLEN_MAX)
        begin
            k_eff = KLEN_MAX;
        end
        else
        begin
            k_eff = kmer_len;
        end
        k_top = k_eff - KLEN_W'(1);

        code    = base_code(item.base_char);
        base_ok = !code[2];

        fwd_cur  = item.read_start ? '0 : fwd_reg;
        rev_cur  = item.read_start ? '0 : rev_reg;
        run_cur  = item.read_start ? '0 : run_reg;
        hist_cur = item.read_start ? '0 : hist_reg;

        rev_shift = {2'b00, rev_cur[KMER_W-1:2]};
        for (int i = 0; i < LANES; i++)
        begin
            tmask[i]       = (KLEN_W'(i) < k_eff);
            fmask[2*i +: 2] = {2{tmask[i]}};
            // complement lands in lane k-1; stale upper bits are kept
            rev_ins[2*i +: 2] = (KLEN_W'(i) == k_top) ? ~code[1:0] : 2'b00;
        end

        // Trust bit enters whatever the letter
        hist_next = {hist_cur[TRUST_W-2:0], ~item.base_error};
        trust_ok  = &(hist_next | ~tmask);

        if (base_ok)
        begin
            fwd_next = ((fwd_cur << 2) | {{(KMER_W-2){1'b0}}, code[1:0]}) & fmask;
            rev_next = rev_shift | rev_ins;
            run_next = (run_cur < k_eff) ? run_cur + KLEN_W'(1) : run_cur;
            emit     = (run_next >= k_eff) && trust_ok;
        end
        else
        begin
            fwd_next = '0;
            rev_next = '0;
            run_next = '0;
            emit     = 1'b0;
        end

        canon           = (fwd_next < rev_next) ? fwd_next : rev_next;
        kmer_valid_next = emit;
        canon_next      = emit ? canon : '0;
        bucket_next     = BUCKET_W'(canon_next & BUCKET_MASK);

        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= '0;
            rev_reg       <= '0;
            run_reg       <= '0;
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                fwd_reg  <= fwd_next;
                rev_reg  <= rev_next;
                run_reg  <= run_next;
                hist_reg <= hist_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kmer_valid_reg <= kmer_valid_next;
            canon_reg      <= canon_next;
            bucket_reg     <= bucket_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kmer_valid     = kmer_valid_reg;
    assign canonical_kmer = canon_reg;
    assign bucket         = bucket_reg;

endmodule

@@ hdl/tcke_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcke_checker
// Port-level checks on the canonical k-mer extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "trusted_canonical_kmer_extractor_defines.svh"

module tcke_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [tcke_pkg::CHAR_W-1:0]    base_char,
    input  logic                           base_error,
    input  logic                           read_start,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           kmer_valid,
    input  logic [tcke_pkg::KMER_W-1:0]    canonical_kmer,
    input  logic [tcke_pkg::BUCKET_W-1:0]  bucket,
    input  logic                           cfg_wr_en,
    input  logic [tcke_pkg::KLEN_W-1:0]    cfg_wr_data
);
    import tcke_pkg::*;

    logic               out_stall;
    logic               no_kmer;
    logic               bucket_ok;
    logic [BUCKET_W-1:0] bucket_exp;

    assign out_stall  = out_valid && !out_ready;
    assign no_kmer    = out_valid && !kmer_valid;
    assign bucket_exp = BUCKET_W'(canonical_kmer & BUCKET_MASK);
    assign bucket_ok  = (bucket == bucket_exp);

    // Stalled result stays put
    `TCKE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable({kmer_valid, canonical_kmer, bucket}), "result changed while stalled")

    // Input side only blocks when a result is waiting
    `TCKE_ASSERT_IMP(a_ready_block, clk, rst_n, !in_ready, out_stall, "in_ready low without a stalled result")

    // No k-mer means zero payload
    `TCKE_ASSERT_IMP(a_zero_payload, clk, rst_n, no_kmer, (canonical_kmer == '0) && (bucket == '0), "payload not zero without k-mer")

    // Bucket follows the k-mer low bits
    `TCKE_ASSERT_IMP(a_bucket, clk, rst_n, out_valid, bucket_ok, "bucket mismatch")

endmodule

bind trusted_canonical_kmer_extractor tcke_checker u_tcke_checker (.*);

@@ verif/trusted_canonical_kmer_extractor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trusted_canonical_kmer_extractor_tb
// Streams read bases through the canonical k-mer extractor and checks each
// result against an in-bench prediction of the k-mers, run length and trust
// window. It starts with a short directed read, then runs phases of random
// reads at several k-mer lengths under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module trusted_canonical_kmer_extractor_tb;

    import tcke_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 250;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_ITEMS  = 105;

    typedef struct packed {
        logic                kmer_valid;
        logic [KMER_W-1:0]   canonical_kmer;
        logic [BUCKET_W-1:0] bucket;
    } kmer_result_t;

    // Tracks read state and holds the results still owed by the block
    class canon_kmer_tracker;
        logic [KLEN_W-1:0]  kmer_len;
        logic [KMER_W-1:0]  fwd_kmer;
        logic [KMER_W-1:0]  rc_kmer;
        int unsigned        run_len;
        logic [TRUST_W-1:0] trust_win;
        kmer_result_t       owed_q[$];
        int unsigned        mismatches;

        function new();
            kmer_len   = KLEN_RESET;
            mismatches = 0;
            clear_read();
        endfunction

        function void clear_read();
            fwd_kmer  = '0;
            rc_kmer   = '0;
            run_len   = 0;
            trust_win = '0;
        endfunction

        function void absorb_base(input logic [CHAR_W-1:0] ch, input logic err,
                                  input logic st);
            int unsigned        k;
            int unsigned        trusted;
            logic [KMER_W-1:0]  fmask;
            logic [TRUST_W-1:0] tmask;
            logic [2:0]         code;
            logic [1:0]         comp;
            kmer_result_t       res;
            k = kmer_len;
            if (k < 1)
                k = 1;
            if (k > MAX_KMER_LEN)
                k = MAX_KMER_LEN;
            fmask = (k == 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
            tmask = (k == 32) ? '1 : ((32'd1 << k) - 32'd1);
            if (st)
                clear_read();
            trust_win = {trust_win[TRUST_W-2:0], ~err};
            trusted   = $countones(trust_win & tmask);
            case (ch & 8'hDF)
                "A":     code = CODE_A;
                "C":     code = CODE_C;
                "G":     code = CODE_G;
                "T":     code = CODE_T;
                default: code = CODE_BAD;
            endcase
            res = '0;
            if (code != CODE_BAD)
            begin
                comp     = 2'd3 - code[1:0];
                fwd_kmer = ((fwd_kmer << 2) | {62'd0, code[1:0]}) & fmask;
                rc_kmer  = (rc_kmer >> 2) | ({62'd0, comp} << ((k - 1) * 2));
                if (run_len < k)
                    run_len++;
                if (run_len >= k && trusted == k)
                begin
                    res.kmer_valid     = 1'b1;
                    res.canonical_kmer = (fwd_kmer < rc_kmer) ? fwd_kmer : rc_kmer;
                end
            end
            else
            begin
                // letter outside ACGT restarts the run; trust window survives
                run_len  = 0;
                fwd_kmer = '0;
                rc_kmer  = '0;
            end
            res.bucket = BUCKET_W'(res.canonical_kmer & BUCKET_MASK);
            owed_q = {owed_q, res};
        endfunction

        function void match_output(input logic kv, input logic [KMER_W-1:0] kmer,
                                   input logic [BUCKET_W-1:0] bkt);
            kmer_result_t want;
            if (owed_q.size() == 0)
            begin
                $display("%0t: result with none owed: kmer_valid=%0b kmer=%h bucket=%h",
                         $time, kv, kmer, bkt);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            if (kv !== want.kmer_valid)
            begin
                $display("%0t: kmer_valid expected %0b got %0b", $time, want.kmer_valid, kv);
                mismatches++;
            end
            if (kmer !== want.canonical_kmer)
            begin
                $display("%0t: canonical_kmer expected %h got %h", $time,
                         want.canonical_kmer, kmer);
                mismatches++;
            end
            if (bkt !== want.bucket)
            begin
                $display("%0t: bucket expected %h got %h", $time, want.bucket, bkt);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CHAR_W-1:0]   base_char;
    logic                base_error;
    logic                read_start;
    logic                out_valid;
    logic                out_ready;
    logic                kmer_valid;
    logic [KMER_W-1:0]   canonical_kmer;
    logic [BUCKET_W-1:0] bucket;
    logic                cfg_wr_en;
    logic [KLEN_W-1:0]   cfg_wr_data;

    canon_kmer_tracker   tracker;
    int unsigned         items_sent;
    int unsigned         gap_pct;
    int unsigned         stall_pct;
    int unsigned         cycles;
    logic                rx_hold;
    event                stall_go;

    trusted_canonical_kmer_extractor u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .base_char      (base_char),
        .base_error     (base_error),
        .read_start     (read_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kmer_valid     (kmer_valid),
        .canonical_kmer (canonical_kmer),
        .bucket         (bucket),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Long receiver hold-off, timed here so the sender keeps pushing
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(stall_go);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.match_output(kmer_valid, canonical_kmer, bucket);
            out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
        else
        begin
            out_ready <= 1'b0;
        end
    end

    task automatic send_base(input logic [CHAR_W-1:0] ch, input logic err,
                             input logic st);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_char  <= ch;
        base_error <= err;
        read_start <= st;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.absorb_base(ch, err, st);
        items_sent++;
    endtask

    task automatic set_kmer_len(input logic [KLEN_W-1:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.kmer_len = len;
    endtask

    // Lets every owed result out through the input and result registers, plus a margin
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.owed_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] letter_of(input logic [2:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            CODE_A:  ch = "A";
            CODE_C:  ch = "C";
            CODE_G:  ch = "G";
            default: ch = "T";
        endcase
        return ch;
    endfunction

    // Mostly clean bases, the odd error and the odd non-ACGT byte
    task automatic feed_read(input int unsigned k_eff, input bit with_start);
        int unsigned       len;
        int unsigned       i;
        logic [CHAR_W-1:0] ch;
        logic              err;
        len = $urandom_range(k_eff + 24, 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 2)
                ch = CHAR_W'($urandom_range(255));
            else
                ch = letter_of(3'($urandom_range(3))) | ($urandom_range(1) ? 8'h20 : 8'h00);
            err = ($urandom_range(99) < 3);
            send_base(ch, err, with_start && i == 0);
        end
    endtask

    task automatic feed_noise();
        int unsigned len;
        int unsigned i;
        len = $urandom_range(20, 1);
        for (i = 0; i < len; i++)
            send_base(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(9) == 0);
    endtask

    function automatic logic [KLEN_W-1:0] phase_length(input int unsigned p);
        logic [KLEN_W-1:0] len;
        case (p)
            0:       len = 6'd32;
            1:       len = 6'd1;
            2:       len = 6'd0;
            3:       len = 6'd63;
            4:       len = 6'd31;
            5:       len = 6'd7;
            6:       len = 6'd33;
            7:       len = 6'd16;
            8:       len = 6'd2;
            9:       len = 6'd24;
            10:      len = 6'd3;
            default: len = 6'd32;
        endcase
        return len;
    endfunction

    initial
    begin : stimulus
        int unsigned       p;
        int unsigned       target;
        int unsigned       k_eff;
        logic [KLEN_W-1:0] len;
        bit                with_start;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        base_char   <= '0;
        base_error  <= 1'b0;
        read_start  <= 1'b0;
        out_ready   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        items_sent  = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        cycles      = 0;
        tracker     = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed read at k = 2
        set_kmer_len(6'd2);
        send_base("A", 1'b0, 1'b1);
        send_base("c", 1'b0, 1'b0);
        send_base("G", 1'b1, 1'b0);
        send_base("t", 1'b0, 1'b0);
        send_base("T", 1'b0, 1'b0);
        send_base("N", 1'b1, 1'b0);   // untrusted restart, trust bit kept
        send_base("a", 1'b0, 1'b0);
        send_base("C", 1'b0, 1'b0);
        send_base("g", 1'b0, 1'b0);
        send_base(8'hFF, 1'b0, 1'b0);
        send_base(8'h00, 1'b0, 1'b0);
        send_base("A", 1'b0, 1'b0);
        send_base("A", 1'b0, 1'b0);   // all-zero forward k-mer
        send_base("T", 1'b0, 1'b1);   // new read mid-stream
        send_base("T", 1'b0, 1'b0);
        send_base("g", 1'b0, 1'b0);
        send_base("c", 1'b0, 1'b0);   // palindrome, both strands equal
        send_base(8'hC1, 1'b0, 1'b0); // folds near 'A' but is not a letter
        send_base("A", 1'b1, 1'b1);
        send_base("C", 1'b0, 1'b0);
        send_base("G", 1'b0, 1'b0);
        drain();

        for (p = 0; p < PHASES; p++)
        begin
            len   = phase_length(p);
            k_eff = (len == 0) ? 1 : ((len > MAX_KMER_LEN) ? MAX_KMER_LEN : len);
            set_kmer_len(len);
            case (p % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    gap_pct   = 11;
                    stall_pct = 11;
                end
            endcase
            if (p == 4 || p == 6)
                -> stall_go;
            // odd phases carry on the previous read under the new length
            with_start = (p % 2 == 0);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(7) == 0)
                    feed_noise();
                else
                    feed_read(k_eff, with_start);
                with_start = 1'b1;
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.owed_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
